### rtl/core/double_ended_queue_assert.svh
// assertion macros for the deque block
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/deq_pkg.sv
package deq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned OPC_W      = 3;
  localparam int unsigned CNT_OUT_W  = 5;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W      = IDX_W + 1;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } deq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } deq_status_e;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [WORD_W-1:0] data_in;
  } deq_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]    front_value;
    logic [WORD_W-1:0]    back_value;
    logic                 is_empty;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [1:0]           status;
  } deq_out_t;

  typedef struct packed {
    logic exec;
    logic rd;
    logic load;
  } deq_cmd_t;

  // circular index add, both operands below DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

### rtl/core/double_ended_queue.sv
// channel | valid      | stall       | word
// input   | in_valid_i | in_stall_o  | in_word_i  (opcode, data_in)
// output  | out_valid_o| out_stall_i | out_word_o (front, back, empty, count, status)
// one item at a time, in order: accept and update, memory read, output load
// the two-port storage read after the pointer update takes its own step
// the output register lets a new word in while a result waits
// a held output stalls only the final load step
// reset clears head, count and handshake state; storage is not cleared
module double_ended_queue
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  deq_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output deq_out_t out_word_o
);

  `include "double_ended_queue_assert.svh"

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  deq_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

  `DEQ_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "second word taken early")
  `DEQ_ASSERT_NOW(a_empty_zero, out_valid_o && out_word_o.is_empty, (out_word_o.front_value == '0) && (out_word_o.back_value == '0), "empty queue shows data")
  `DEQ_ASSERT_NOW(a_empty_count, out_valid_o, out_word_o.is_empty == (out_word_o.entry_count == '0), "empty flag and count disagree")
  `DEQ_ASSERT_NOW(a_count_range, out_valid_o, (out_word_o.entry_count <= CNT_OUT_W'(DEPTH)) && (out_word_o.status != 2'd3), "count or status out of range")

endmodule

### rtl/core/deq_ctrl.sv
module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output deq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   out_vld_q;
  logic   out_free;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign cmd_o.exec = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.rd   = (state_q == S_READ);
  assign cmd_o.load = (state_q == S_LOAD) && out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_o.load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/deq_dpath.sv
module deq_dpath
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  deq_cmd_t cmd_i,
  input  deq_in_t  in_word_i,
  output deq_out_t out_word_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  deq_status_e           st_q, st_d;
  logic                  we;
  logic [IDX_W-1:0]      wr_idx;
  logic                  full, empty;
  logic [DATA_WIDTH-1:0] rd_front_q, rd_back_q;
  logic [IDX_W-1:0]      back_idx;
  deq_out_t              out_q;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    st_d    = ST_OK;
    we      = 1'b0;
    wr_idx  = head_q;
    case (deq_op_e'(in_word_i.opcode))
      OP_PUSH_FRONT: begin
        if (full) begin
          st_d = ST_PUSH_FULL;
        end else begin
          head_d  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
          wr_idx  = head_d;
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st_d = ST_PUSH_FULL;
        end else begin
          wr_idx  = wrap_add(head_q, count_q[IDX_W-1:0]);
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st_d = ST_POP_EMPTY;
        end else begin
          head_d  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st_d = ST_POP_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  assign back_idx = wrap_add(head_q, IDX_W'(count_q - 1'b1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      st_q    <= ST_OK;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
      st_q    <= st_d;
    end
  end

  // storage, write on accept and registered reads in the cycle after
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[wr_idx] <= in_word_i.data_in[DATA_WIDTH-1:0];
    end
    if (cmd_i.rd) begin
      rd_front_q <= mem[head_q];
      rd_back_q  <= mem[back_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.front_value <= empty ? '0 : WORD_W'(rd_front_q);
      out_q.back_value  <= empty ? '0 : WORD_W'(rd_back_q);
      out_q.is_empty    <= empty;
      out_q.entry_count <= CNT_OUT_W'(count_q);
      out_q.status      <= st_q;
    end
  end

  assign out_word_o = out_q;

endmodule

### bench/tb_double_ended_queue.sv
`timescale 1ns / 100ps

module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [WORD_W-1:0] DATA_KEEP = {WORD_W{1'b1}} >> (WORD_W - DATA_WIDTH);

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  deq_in_t  in_word_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  deq_out_t out_word_o;

  double_ended_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // mirror of the deque contents
  logic [WORD_W-1:0] mirror_store [DEPTH];
  int unsigned       mirror_head = 0;
  int unsigned       mirror_fill = 0;
  deq_out_t          views_q [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned hold_req_seq = 0;
  int unsigned hold_seen_seq = 0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  task automatic apply_deque_op(input deq_in_t w);
    deq_out_t v;
    logic [WORD_W-1:0] kept;
    kept = w.data_in & DATA_KEEP;
    v = '0;
    v.status = ST_OK;
    if (w.opcode == OP_PUSH_FRONT || w.opcode == OP_PUSH_BACK) begin
      if (mirror_fill >= DEPTH) begin
        v.status = ST_PUSH_FULL;
      end else begin
        if (w.opcode == OP_PUSH_FRONT) begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_store[mirror_head] = kept;
        end else begin
          mirror_store[(mirror_head + mirror_fill) % DEPTH] = kept;
        end
        mirror_fill++;
      end
    end else if (w.opcode == OP_POP_FRONT || w.opcode == OP_POP_BACK) begin
      if (mirror_fill == 0) begin
        v.status = ST_POP_EMPTY;
      end else begin
        if (w.opcode == OP_POP_FRONT) begin
          mirror_head = (mirror_head + 1) % DEPTH;
        end
        mirror_fill--;
      end
    end
    if (mirror_fill != 0) begin
      v.front_value = mirror_store[mirror_head];
      v.back_value  = mirror_store[(mirror_head + mirror_fill - 1) % DEPTH];
    end
    v.is_empty    = (mirror_fill == 0);
    v.entry_count = CNT_OUT_W'(mirror_fill);
    views_q.push_back(v);
  endtask

  task automatic send_word(input logic [OPC_W-1:0] op, input logic [WORD_W-1:0] data);
    deq_in_t w;
    w.opcode  = op;
    w.data_in = data;
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    apply_deque_op(w);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (views_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [OPC_W-1:0] pick_opcode(input int unsigned push_weight);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return OP_QUERY;
    if (r < 7) return OPC_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    if (r < 7 + push_weight) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  function automatic logic [WORD_W-1:0] pick_data();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [WORD_W-1:0] d;
    send_word(OP_POP_FRONT, 32'hDEAD_BEEF);
    send_word(OP_POP_BACK, '1);
    send_word(OP_QUERY, '0);
    send_word(OP_SPARE_LO, '1);
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: d = '0;
        1: d = '1;
        2: d = 32'h5555_5555;
        3: d = 32'hAAAA_AAAA;
        default: d = $urandom;
      endcase
      send_word(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, d);
    end
    send_word(OP_PUSH_FRONT, 32'h1234_5678);
    send_word(OP_PUSH_BACK, '1);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_BACK, '0);
    send_word(OP_SPARE_HI, '0);
    send_word(OPC_W'(OP_SPARE_LO + 1), '1);
  endtask

  task automatic test_long_hold();
    tx_idle_en = 1'b0;
    hold_req_seq++;
    repeat (40) send_word(pick_opcode(75), pick_data());
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (15) send_word(pick_opcode(50), pick_data());
    wait_drained();
    repeat (15) send_word(pick_opcode(50), pick_data());
  endtask

  task automatic test_random_mix();
    int unsigned push_w;
    for (int seg = 0; seg < 16; seg++) begin
      tx_idle_en = (seg % 3 != 2);
      rx_idle_en = (seg % 4 != 3);
      case (seg % 3)
        0: push_w = 70;
        1: push_w = 20;
        default: push_w = 46;
      endcase
      repeat (50) send_word(pick_opcode(push_w), pick_data());
    end
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (80) send_word(pick_opcode(46), pick_data());
  endtask

  // receiver side stall generation
  always @(posedge clk_i) begin
    if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq <= hold_req_seq;
      hold_left     <= HOLD_CYCLES;
      out_stall_i   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left  <= burst_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      burst_left  <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string fname, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    deq_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (views_q.size() == 0) begin
        $display("%0t: word with none expected, expected nothing actual %h", $time, out_word_o);
        mismatches++;
      end else begin
        want = views_q.pop_front();
        check_field("front_value", want.front_value, out_word_o.front_value);
        check_field("back_value", want.back_value, out_word_o.back_value);
        check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(out_word_o.is_empty));
        check_field("entry_count", WORD_W'(want.entry_count),
                    WORD_W'(out_word_o.entry_count));
        check_field("status", WORD_W'(want.status), WORD_W'(out_word_o.status));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL double_ended_queue");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_hold();
    test_drain_pause();
    test_random_mix();
    test_full_rate();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_dpath.sv
rtl/core/double_ended_queue.sv
bench/tb_double_ended_queue.sv
